>>> rtl/wme_pkg.sv
// ----------------------------------------------------------------------------
// wme_pkg
// Shared constants, types and character helpers of the WSPR message encoder.
// ----------------------------------------------------------------------------
package wme_pkg;

    localparam int SYMBOLS_PER_WORD_DEF = 18;
    localparam int SYM_TOTAL            = 162;
    localparam int ADDR_W               = 8;
    localparam int WORD_BITS            = 36;
    localparam int WORD_SYMS            = WORD_BITS / 2;
    localparam int MSG_BITS             = 50;
    localparam int N_BITS               = 28;
    localparam int M_BITS               = 22;
    localparam int NUM_CHARS            = 6;

    localparam logic [31:0] POLY_A = 32'hF2D0_5351;
    localparam logic [31:0] POLY_B = 32'hE461_3C47;

    // Sync vector, bit r is the sync bit of channel symbol r.
    localparam logic [0:SYM_TOTAL-1] SYNC_SEQ = {
        20'b11000000100011100010,
        20'b01011110000000100101,
        20'b00000010110011010001,
        20'b10100001101010101001,
        20'b00101100011010100010,
        20'b00001001001110110011,
        20'b01000111000001010011,
        20'b00000001101011000110,
        2'b00
    };

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CALL  = 2'd1;
    localparam logic [1:0] STATUS_BAD_GRID  = 2'd2;
    localparam logic [1:0] STATUS_BAD_POWER = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UR    = 8'h52;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // One write into the symbol store.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        data;
    } sym_wr_t;

    // One step of the shared multiply-add unit: acc = acc * mul + add.
    typedef struct packed {
        logic              en;
        logic signed [8:0] mul;
        logic [31:0]       add;
    } mac_op_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) ? c - CASE_OFS : c;
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd36;
        if (is_digit(c))
            d = c - CH_0;
        else if ((c >= CH_UA) && (c <= CH_UZ))
            d = c - CH_UA + 8'd10;
        return d[5:0];
    endfunction

    function automatic logic power_ok(input logic [5:0] p);
        logic ok;
        case (p)
            6'd0, 6'd3, 6'd7, 6'd10, 6'd13, 6'd17, 6'd20, 6'd23, 6'd27, 6'd30,
            6'd33, 6'd37, 6'd40, 6'd43, 6'd47, 6'd50, 6'd53, 6'd57, 6'd60:
                ok = 1'b1;
            default:
                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/wme_mac.sv
// ----------------------------------------------------------------------------
// wme_mac
// Shared multiply-add unit used to build the callsign and locator numbers.
// ----------------------------------------------------------------------------
module wme_mac (
    input  logic             clk,
    input  logic             rst_n,
    input  wme_pkg::mac_op_t op,
    output logic [31:0]      acc
);
    import wme_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] mul_ext;

    // Wrapping 32-bit arithmetic, negative factors in two's complement
    assign mul_ext  = {{23{op.mul[8]}}, op.mul};
    assign acc_next = 32'(acc_reg * mul_ext) + op.add;
    assign acc      = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> rtl/wme_symbol_ram.sv
// ----------------------------------------------------------------------------
// wme_symbol_ram
// Channel symbol store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wme_symbol_ram (
    input  logic                       clk,
    input  wme_pkg::sym_wr_t           wr,
    input  logic                       rd_en,
    input  logic [wme_pkg::ADDR_W-1:0] rd_addr,
    output logic [1:0]                 rd_data
);
    import wme_pkg::*;

    logic [1:0] mem [SYM_TOTAL];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/wme_interleaver.sv
// ----------------------------------------------------------------------------
// wme_interleaver
// K=32 rate 1/2 convolutional coder walking the 256 bit-reversed slots.
// ----------------------------------------------------------------------------
module wme_interleaver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wme_pkg::MSG_BITS-1:0] msg,
    output logic                         done,
    output wme_pkg::sym_wr_t             wr
);
    import wme_pkg::*;

    logic                busy_reg;
    logic [7:0]          slot_reg;
    logic                phase_reg;
    logic [31:0]         sr_reg;
    logic [MSG_BITS-1:0] msg_reg;

    logic [7:0]          rev;
    logic                slot_ok;
    logic [31:0]         sr_shift;
    logic                code_bit;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            rev[b] = slot_reg[7 - b];
        end
    end

    assign slot_ok  = rev < 8'(SYM_TOTAL);
    // message register drains to zero, which supplies the tail bits
    assign sr_shift = {sr_reg[30:0], msg_reg[MSG_BITS-1]};
    assign code_bit = phase_reg ? ^(sr_reg & POLY_B) : ^(sr_shift & POLY_A);

    assign wr.en   = busy_reg && slot_ok;
    assign wr.addr = rev;
    assign wr.data = {code_bit, SYNC_SEQ[rev]};
    assign done    = busy_reg && (slot_reg == 8'hFF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            slot_reg  <= '0;
            phase_reg <= 1'b0;
            sr_reg    <= '0;
            msg_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            slot_reg  <= '0;
            phase_reg <= 1'b0;
            sr_reg    <= '0;
            msg_reg   <= msg;
        end
        else if (busy_reg)
        begin
            if (slot_ok)
            begin
                phase_reg <= ~phase_reg;
                if (!phase_reg)
                begin
                    sr_reg  <= sr_shift;
                    msg_reg <= {msg_reg[MSG_BITS-2:0], 1'b0};
                end
            end
            slot_reg <= slot_reg + 8'd1;
            if (slot_reg == 8'hFF)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/wspr_message_encoder.sv
// ----------------------------------------------------------------------------
// wspr_message_encoder
// WSPR type 1 message check, packing, coding, interleaving and symbol output.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one message (callsign bytes, length,
// grid bytes, power). in_ready is high only while the block is idle.
// Output channel: out_valid/out_ready carry result beats, each with status,
// word_index, symbols_word, symbol_count and last.
// A rejected message gives one beat with the error status, straight from the
// check state. A valid message passes the check, the multiply-add steps in
// the shared unit, the 256-slot walk of the coder (one interleave slot a
// cycle), then per word up to min(SYMBOLS_PER_WORD, 18) symbol store reads
// plus the output wait. The 256-slot interleave walk is the longest step
// when the output does not stall.
// When out_ready is low the current beat holds and the block waits; no
// result is dropped. Reset returns the block to idle with no beat pending;
// the symbol store needs no clearing since every entry is written first.
// ----------------------------------------------------------------------------
module wspr_message_encoder #(
    parameter int SYMBOLS_PER_WORD = wme_pkg::SYMBOLS_PER_WORD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] callsign_chars,
    input  logic [3:0]  callsign_length,
    input  logic [31:0] grid_chars,
    input  logic [5:0]  tx_power,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  word_index,
    output logic [35:0] symbols_word,
    output logic [4:0]  symbol_count,
    output logic        last
);
    import wme_pkg::*;

    localparam int NUM_WORDS = (SYM_TOTAL + SYMBOLS_PER_WORD - 1) / SYMBOLS_PER_WORD;
    localparam int WCNT_W    = $clog2(NUM_WORDS);
    localparam logic [7:0] SPW8      = 8'(SYMBOLS_PER_WORD);
    localparam logic [7:0] WSYMS8    = 8'(WORD_SYMS);
    localparam logic [3:0] STEP_DONE = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CALC,
        ST_ENCODE,
        ST_READ,
        ST_SEND
    } state_t;

    state_t              state_reg;
    logic [47:0]         cs_reg;
    logic [3:0]          len_reg;
    logic [31:0]         grid_reg;
    logic [5:0]          pwr_reg;
    logic [3:0]          step_reg;
    logic [N_BITS-1:0]   n_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [WCNT_W-1:0]   w_reg;
    logic [4:0]          k_reg;
    logic [4:0]          pk_reg;
    logic                pend_reg;
    logic [1:0]          status_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [4:0]          count_reg;
    logic                last_reg;

    logic [7:0]  ch [NUM_CHARS];
    logic [7:0]  g  [4];
    logic [5:0]  pad_val [NUM_CHARS];
    logic        call_ok;
    logic        grid_ok;
    logic [1:0]  chk_status;
    logic        pad_shift;
    logic [7:0]  gu0;
    logic [7:0]  gu1;
    logic [31:0] l1, l2, l3, l4;

    mac_op_t     mac_op;
    logic [31:0] acc;
    logic        enc_start;
    logic        enc_done;
    sym_wr_t     sym_wr;

    logic [7:0]        remain;
    logic [7:0]        word_cnt;
    logic [4:0]        read_cnt;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        rd_data;
    logic [8:0]        base_sum;

    // ------------------------------------------------------------ checks
    always_comb
    begin
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            ch[i] = cs_reg[8*i +: 8];
        end
        for (int i = 0; i < 4; i++)
        begin
            g[i] = grid_reg[8*i +: 8];
        end
    end

    always_comb
    begin
        call_ok = (len_reg >= 4'd2) && (len_reg <= 4'd6);
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            if ((4'(i) < len_reg) && !is_letter(ch[i]) && !is_digit(ch[i])
                && (ch[i] != CH_SLASH))
            begin
                call_ok = 1'b0;
            end
        end
    end

    assign gu0     = to_upper(g[0]);
    assign gu1     = to_upper(g[1]);
    assign grid_ok = (gu0 >= CH_UA) && (gu0 <= CH_UR) && (gu1 >= CH_UA) && (gu1 <= CH_UR)
                     && is_digit(g[2]) && is_digit(g[3]);

    always_comb
    begin
        if (!call_ok)
            chk_status = STATUS_BAD_CALL;
        else if (!grid_ok)
            chk_status = STATUS_BAD_GRID;
        else if (!power_ok(pwr_reg))
            chk_status = STATUS_BAD_POWER;
        else
            chk_status = STATUS_OK;
    end

    // ------------------------------------------------------------ padding
    // letter then digit: one leading space, so the digit lands in position 2
    assign pad_shift = is_letter(ch[0]) && is_digit(ch[1]);

    always_comb
    begin
        logic [2:0] src;
        logic [7:0] pc;
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            src = 3'(i) - {2'b00, pad_shift};
            if (pad_shift && (i == 0))
                pc = CH_SPACE;
            else if ({1'b0, src} < len_reg)
                pc = to_upper(ch[src]);
            else
                pc = CH_SPACE;
            pad_val[i] = char_value(pc);
        end
    end

    assign l1 = {24'd0, gu0 - CH_UA};
    assign l2 = {24'd0, gu1 - CH_UA};
    assign l3 = {24'd0, g[2] - CH_0};
    assign l4 = {24'd0, g[3] - CH_0};

    // --------------------------------------------- multiply-add sequence
    // steps 0..5 build the callsign number, 6..10 the locator and power
    always_comb
    begin
        mac_op.en  = (state_reg == ST_CALC);
        mac_op.mul = 9'sd0;
        mac_op.add = '0;
        case (step_reg)
            4'd0:
            begin
                mac_op.mul = 9'sd0;
                mac_op.add = {26'd0, pad_val[0]};
            end
            4'd1:
            begin
                mac_op.mul = 9'sd36;
                mac_op.add = {26'd0, pad_val[1]};
            end
            4'd2:
            begin
                mac_op.mul = 9'sd10;
                mac_op.add = {26'd0, pad_val[2]};
            end
            4'd3:
            begin
                mac_op.mul = 9'sd27;
                mac_op.add = {26'd0, pad_val[3]} - 32'd10;
            end
            4'd4:
            begin
                mac_op.mul = 9'sd27;
                mac_op.add = {26'd0, pad_val[4]} - 32'd10;
            end
            4'd5:
            begin
                mac_op.mul = 9'sd27;
                mac_op.add = {26'd0, pad_val[5]} - 32'd10;
            end
            4'd6:
            begin
                mac_op.mul = 9'sd0;
                mac_op.add = l1;
            end
            4'd7:
            begin
                mac_op.mul = -9'sd10;
                mac_op.add = 32'd179 - l3;
            end
            4'd8:
            begin
                mac_op.mul = 9'sd18;
                mac_op.add = l2;
            end
            4'd9:
            begin
                mac_op.mul = 9'sd10;
                mac_op.add = l4;
            end
            4'd10:
            begin
                mac_op.mul = 9'sd128;
                mac_op.add = {26'd0, pwr_reg} + 32'd64;
            end
            default:
            begin
                mac_op.en = 1'b0;
            end
        endcase
    end

    wme_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    assign enc_start = (state_reg == ST_CALC) && (step_reg == STEP_DONE);

    wme_interleaver u_interleaver (
        .clk   (clk),
        .rst_n (rst_n),
        .start (enc_start),
        .msg   ({n_reg, acc[M_BITS-1:0]}),
        .done  (enc_done),
        .wr    (sym_wr)
    );

    // ------------------------------------------------------ word readout
    assign remain   = 8'(SYM_TOTAL) - base_reg;
    assign word_cnt = (remain > SPW8) ? SPW8 : remain;
    // only the first symbols of a word fit the output field
    assign read_cnt = (word_cnt > WSYMS8) ? 5'(WORD_SYMS) : word_cnt[4:0];
    assign rd_en    = (state_reg == ST_READ) && (k_reg < read_cnt);
    assign rd_addr  = base_reg + {3'd0, k_reg};
    assign base_sum = {1'b0, base_reg} + {1'b0, SPW8};

    wme_symbol_ram u_ram (
        .clk     (clk),
        .wr      (sym_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cs_reg     <= '0;
            len_reg    <= '0;
            grid_reg   <= '0;
            pwr_reg    <= '0;
            step_reg   <= '0;
            n_reg      <= '0;
            base_reg   <= '0;
            w_reg      <= '0;
            k_reg      <= '0;
            pk_reg     <= '0;
            pend_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            word_reg   <= '0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cs_reg    <= callsign_chars;
                        len_reg   <= callsign_length;
                        grid_reg  <= grid_chars;
                        pwr_reg   <= tx_power;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    step_reg <= '0;
                    if (chk_status != STATUS_OK)
                    begin
                        status_reg <= chk_status;
                        word_reg   <= '0;
                        count_reg  <= '0;
                        w_reg      <= '0;
                        last_reg   <= 1'b1;
                        state_reg  <= ST_SEND;
                    end
                    else
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (step_reg == 4'd6)
                    begin
                        n_reg <= acc[N_BITS-1:0];
                    end
                    if (step_reg == STEP_DONE)
                    begin
                        state_reg <= ST_ENCODE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_ENCODE:
                begin
                    if (enc_done)
                    begin
                        status_reg <= STATUS_OK;
                        base_reg   <= '0;
                        w_reg      <= '0;
                        k_reg      <= '0;
                        pk_reg     <= '0;
                        pend_reg   <= 1'b0;
                        word_reg   <= '0;
                        state_reg  <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    pend_reg <= rd_en;
                    if (rd_en)
                    begin
                        k_reg <= k_reg + 5'd1;
                    end
                    // read data comes back through the store's read register, flagged by pend_reg
                    if (pend_reg)
                    begin
                        word_reg[{pk_reg, 1'b0} +: 2] <= rd_data;
                        pk_reg <= pk_reg + 5'd1;
                    end
                    if (!rd_en && !pend_reg)
                    begin
                        count_reg <= word_cnt[4:0];
                        last_reg  <= (w_reg == WCNT_W'(NUM_WORDS - 1));
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    if (out_ready)
                    begin
                        if (last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            base_reg  <= base_sum[ADDR_W-1:0];
                            w_reg     <= w_reg + WCNT_W'(1);
                            k_reg     <= '0;
                            pk_reg    <= '0;
                            pend_reg  <= 1'b0;
                            word_reg  <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_SEND);
    assign status       = status_reg;
    assign word_index   = 4'(w_reg);
    assign symbols_word = word_reg;
    assign symbol_count = count_reg;
    assign last         = last_reg;

endmodule

>>> dv/wspr_message_encoder_test.sv
// ----------------------------------------------------------------------------
// wspr_message_encoder_test
// Self-checking bench for the WSPR type 1 message encoder. Messages are sent
// over the input channel and a local encoder computes the beats each one
// should produce. That encoder covers the checks, padding, packing,
// convolutional coding, interleave and sync merge. Every output beat is
// compared field by field, in order. Directed messages come first, then
// random ones, then back-to-back traffic and a long output stall.
// ----------------------------------------------------------------------------
module wspr_message_encoder_test;
    import wme_pkg::*;

    localparam int SYM_PER_BEAT = SYMBOLS_PER_WORD_DEF;
    localparam int NUM_SYMBOLS  = 162;
    localparam int NUM_BEATS    = (NUM_SYMBOLS + SYM_PER_BEAT - 1) / SYM_PER_BEAT;
    localparam int CODED_BITS   = 81;
    localparam logic [31:0] CODE_POLY_0 = 32'hF2D0_5351;
    localparam logic [31:0] CODE_POLY_1 = 32'hE461_3C47;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    // sync bit of channel symbol r is SYNC_VEC[r]
    localparam logic [0:NUM_SYMBOLS-1] SYNC_VEC = {
        20'b11000000100011100010,
        20'b01011110000000100101,
        20'b00000010110011010001,
        20'b10100001101010101001,
        20'b00101100011010100010,
        20'b00001001001110110011,
        20'b01000111000001010011,
        20'b00000001101011000110,
        2'b00
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  word_index;
        logic [35:0] symbols_word;
        logic [4:0]  symbol_count;
        logic        last;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [47:0] callsign_chars = '0;
    logic [3:0]  callsign_length = '0;
    logic [31:0] grid_chars = '0;
    logic [5:0]  tx_power = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  word_index;
    logic [35:0] symbols_word;
    logic [4:0]  symbol_count;
    logic        last;

    beat_t expected_beats[$];
    int    errors = 0;
    int    beats_checked = 0;
    int    messages_sent = 0;
    int    encoded_msgs = 0;
    int    rejected_msgs = 0;
    int    cycle_count = 0;
    int    hold_request = 0;
    bit    no_idle = 1'b0;

    wspr_message_encoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .callsign_chars  (callsign_chars),
        .callsign_length (callsign_length),
        .grid_chars      (grid_chars),
        .tx_power        (tx_power),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .word_index      (word_index),
        .symbols_word    (symbols_word),
        .symbol_count    (symbol_count),
        .last            (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d beats still expected",
                 cycle_count, expected_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character helpers and message encoder
    // ------------------------------------------------------------------
    function automatic logic is_num(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'h20 : c;
    endfunction

    function automatic logic is_call_char(input logic [7:0] c);
        return is_alpha(c) || is_num(c) || (c == "/");
    endfunction

    function automatic logic grid_letter_ok(input logic [7:0] c);
        logic [7:0] u;
        u = upcase(c);
        return (u >= "A") && (u <= "R");
    endfunction

    // allowed power levels: 0,3,7,10,13,17,...,57,60
    function automatic logic [5:0] power_level(input int idx);
        int step;
        step = (idx % 3 == 0) ? 0 : ((idx % 3 == 1) ? 3 : 7);
        return 6'((idx / 3) * 10 + step);
    endfunction

    function automatic logic power_allowed(input logic [5:0] p);
        logic ok;
        ok = 1'b0;
        for (int i = 0; i < 19; i++)
            if (power_level(i) == p)
                ok = 1'b1;
        return ok;
    endfunction

    function automatic logic [31:0] sym_value(input logic [7:0] c);
        if (is_num(c))
            return 32'(c) - 32'h30;
        if ((c >= "A") && (c <= "Z"))
            return 32'(c) - 32'h41 + 32'd10;
        return 32'd36;
    endfunction

    function automatic logic [47:0] pack_text(input string s);
        logic [47:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 6; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Queue the beats one accepted message should produce.
    task automatic encode_message(input logic [47:0] cs, input logic [3:0] len,
                                  input logic [31:0] grid, input logic [5:0] pwr);
        logic [7:0]  ch [6];
        logic [7:0]  g [4];
        logic [7:0]  pad [6];
        logic [1:0]  st;
        logic [31:0] n;
        logic [31:0] m;
        logic [31:0] l1, l2, l3, l4;
        logic [49:0] msg;
        logic [31:0] shreg;
        logic        code [NUM_SYMBOLS];
        logic [1:0]  sym [NUM_SYMBOLS];
        logic [7:0]  jb, rv;
        logic        in_bit;
        int          dst, src, base, cnt;
        beat_t       b;

        for (int i = 0; i < 6; i++)
            ch[i] = cs[8*i +: 8];
        for (int i = 0; i < 4; i++)
            g[i] = grid[8*i +: 8];

        // checks run callsign, grid, power; first failure wins
        st = STATUS_OK;
        if (len < 2 || len > 6)
            st = STATUS_BAD_CALL;
        else
            for (int i = 0; i < 6; i++)
                if (i < len && !is_call_char(ch[i]))
                    st = STATUS_BAD_CALL;
        if (st == STATUS_OK)
            if (!grid_letter_ok(g[0]) || !grid_letter_ok(g[1]) || !is_num(g[2]) ||
                !is_num(g[3]))
                st = STATUS_BAD_GRID;
        if (st == STATUS_OK && !power_allowed(pwr))
            st = STATUS_BAD_POWER;

        if (st != STATUS_OK)
        begin
            b.status       = st;
            b.word_index   = '0;
            b.symbols_word = '0;
            b.symbol_count = '0;
            b.last         = 1'b1;
            expected_beats.push_back(b);
            rejected_msgs++;
            return;
        end

        // letter then digit gets a leading space; upper-case, fit to six
        dst = 0;
        if (is_alpha(ch[0]) && is_num(ch[1]))
        begin
            pad[0] = " ";
            dst = 1;
        end
        for (int i = 0; i < 6; i++)
            if (i < len && dst < 6)
            begin
                pad[dst] = upcase(ch[i]);
                dst++;
            end
        while (dst < 6)
        begin
            pad[dst] = " ";
            dst++;
        end

        // 32-bit wrapping, as odd calls can underflow the minus-ten terms
        n = sym_value(pad[0]);
        n = n * 32'd36 + sym_value(pad[1]);
        n = n * 32'd10 + sym_value(pad[2]);
        n = n * 32'd27 + sym_value(pad[3]) - 32'd10;
        n = n * 32'd27 + sym_value(pad[4]) - 32'd10;
        n = n * 32'd27 + sym_value(pad[5]) - 32'd10;

        l1 = 32'(upcase(g[0])) - 32'h41;
        l2 = 32'(upcase(g[1])) - 32'h41;
        l3 = 32'(g[2]) - 32'h30;
        l4 = 32'(g[3]) - 32'h30;
        m  = (32'd179 - 32'd10 * l1 - l3) * 32'd180 + 32'd10 * l2 + l4;
        m  = m * 32'd128 + 32'(pwr) + 32'd64;
        msg = {n[27:0], m[21:0]};

        shreg = '0;
        for (int i = 0; i < CODED_BITS; i++)
        begin
            in_bit = (i < 50) ? msg[49 - i] : 1'b0;
            shreg = {shreg[30:0], in_bit};
            code[2*i]     = ^(shreg & CODE_POLY_0);
            code[2*i + 1] = ^(shreg & CODE_POLY_1);
        end

        src = 0;
        for (int j = 0; j < 256; j++)
        begin
            jb = 8'(j);
            for (int k = 0; k < 8; k++)
                rv[7 - k] = jb[k];
            if (src < NUM_SYMBOLS && rv < NUM_SYMBOLS)
            begin
                sym[rv] = {code[src], SYNC_VEC[rv]};
                src++;
            end
        end

        for (int w = 0; w < NUM_BEATS; w++)
        begin
            base = w * SYM_PER_BEAT;
            cnt  = NUM_SYMBOLS - base;
            if (cnt > SYM_PER_BEAT)
                cnt = SYM_PER_BEAT;
            b.status       = STATUS_OK;
            b.word_index   = 4'(w);
            b.symbols_word = '0;
            for (int k = 0; k < cnt; k++)
                b.symbols_word[2*k +: 2] = sym[base + k];
            b.symbol_count = 5'(cnt);
            b.last         = (w == NUM_BEATS - 1);
            expected_beats.push_back(b);
        end
        encoded_msgs++;
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_message(input logic [47:0] cs, input logic [3:0] len,
                                input logic [31:0] grid, input logic [5:0] pwr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        callsign_chars  <= cs;
        callsign_length <= len;
        grid_chars      <= grid;
        tx_power        <= pwr;
        do
            @(posedge clk);
        while (!in_ready);
        encode_message(cs, len, grid, pwr);
        messages_sent++;
    endtask

    task automatic send_text(input string call, input int len, input string grid,
                             input int pwr);
        logic [47:0] gv;
        gv = pack_text(grid);
        send_message(pack_text(call), 4'(len), gv[31:0], 6'(pwr));
    endtask

    // Mostly well-formed messages with random content; the rest broken or noise.
    task automatic send_random_message();
        logic [47:0] cs;
        logic [3:0]  len;
        logic [31:0] grid;
        logic [5:0]  pwr;
        logic [7:0]  b;
        int          kind, pos;

        cs  = {16'($urandom), 32'($urandom)};
        len = 4'($urandom_range(2, 6));
        for (int i = 0; i < 6; i++)
            if (i < len)
                case ($urandom_range(0, 3))
                    0: cs[8*i +: 8] = 8'(8'h41 + $urandom_range(0, 25));
                    1: cs[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 25));
                    2: cs[8*i +: 8] = 8'(8'h30 + $urandom_range(0, 9));
                    default: cs[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'h2F :
                                            8'(8'h41 + $urandom_range(0, 25));
                endcase
        // steer toward the letter-digit prefix that takes a leading space
        if ($urandom_range(0, 2) == 0)
            cs[15:8] = 8'(8'h30 + $urandom_range(0, 9));
        for (int i = 0; i < 2; i++)
            grid[8*i +: 8] = 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) +
                                $urandom_range(0, 17));
        for (int i = 2; i < 4; i++)
            grid[8*i +: 8] = 8'(8'h30 + $urandom_range(0, 9));
        pwr = power_level($urandom_range(0, 18));

        kind = $urandom_range(0, 99);
        if (kind >= 70)
            case (kind % 5)
                0:
                begin
                    do
                        len = 4'($urandom);
                    while (len >= 2 && len <= 6);
                end
                1:
                begin
                    pos = $urandom_range(0, len - 1);
                    do
                        b = 8'($urandom);
                    while (is_call_char(b));
                    cs[8*pos +: 8] = b;
                end
                2:
                begin
                    pos = $urandom_range(0, 3);
                    do
                        b = 8'($urandom);
                    while ((pos < 2) ? grid_letter_ok(b) : is_num(b));
                    grid[8*pos +: 8] = b;
                end
                3:
                begin
                    do
                        pwr = 6'($urandom);
                    while (power_allowed(pwr));
                end
                default:
                begin
                    cs   = {16'($urandom), 32'($urandom)};
                    len  = 4'($urandom);
                    grid = $urandom;
                    pwr  = 6'($urandom);
                end
            endcase
        send_message(cs, len, grid, pwr);
    endtask

    // ------------------------------------------------------------------
    // Output side: per-beat stall, optional long hold, in-order compare
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [35:0] want_v,
                                 input logic [35:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: beat %0d %s mismatch, expected %0h, actual %0h",
                     $time, beats_checked, name, want_v, got_v);
            errors++;
        end
    endtask

    initial
    begin : result_sink
        int    beat_stall;
        int    hold_left;
        beat_t want;
        beat_stall = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual status %0d word %0d",
                             $time, status, word_index);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("status", 36'(want.status), 36'(status));
                    compare_field("word_index", 36'(want.word_index), 36'(word_index));
                    compare_field("symbols_word", want.symbols_word, symbols_word);
                    compare_field("symbol_count", 36'(want.symbol_count), 36'(symbol_count));
                    compare_field("last", 36'(want.last), 36'(last));
                end
                beats_checked++;
                beat_stall = no_idle ? 0 : $urandom_range(0, 11);
            end
            else if (out_valid && beat_stall != 0)
            begin
                beat_stall--;
            end
            if (hold_left != 0)
                hold_left--;
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            out_ready <= (beat_stall == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_messages();
        send_text("K1ABC", 5, "FN42", 37);      // letter+digit gets leading space
        send_text("AB", 2, "AA00", 0);          // shortest call, lowest grid/power
        send_text("ab1cde", 6, "rr99", 60);     // lower case, top grid and power
        send_text("A1BCDE", 6, "JO01", 30);     // padded then cut to six
        send_text("//////", 6, "LL55", 10);     // slashes map to the space value
        send_text("123456", 6, "IO91", 23);
        send_text("Q0", 2, "aR09", 3);
        send_text("zz9zzz", 6, "Ij47", 57);
        send_text("K1ABC!", 5, "FN42", 7);      // byte past the length is ignored
        send_text("K1ABC", 0, "FN42", 37);
        send_text("K1ABC", 1, "FN42", 37);
        send_text("K1ABCD", 7, "FN42", 37);
        send_text("K1ABC", 15, "FN42", 37);
        send_text("K1-BC", 5, "FN42", 37);
        send_text("K1ABC", 5, "SA00", 37);
        send_text("K1ABC", 5, "As00", 37);
        send_text("K1ABC", 5, "@A00", 37);
        send_text("K1ABC", 5, "AA0A", 37);
        send_text("K1ABC", 5, "AA:0", 37);
        send_text("K1ABC", 5, "FN42", 1);
        send_text("K1ABC", 5, "FN42", 61);
        send_text("K1ABC", 5, "FN42", 63);
        send_text("K1ABC", 5, "ZZ00", 63);      // grid fails before power
        send_message('0, '0, '0, '0);           // callsign check comes first
        send_message('1, '1, '1, '1);
    endtask

    task automatic test_random_messages();
        repeat (210) send_random_message();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (15) send_random_message();
        no_idle = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls.
    task automatic test_output_stall();
        hold_request = HOLD_CYCLES;
        repeat (4) send_random_message();
    endtask

    initial
    begin : main
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_messages();
        test_random_messages();
        test_back_to_back();
        test_output_stall();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d messages (%0d encoded, %0d rejected), checked %0d beats.",
                 messages_sent, encoded_msgs, rejected_msgs, beats_checked);
        $display("Covered field extremes, all reject paths, padding, gapless traffic, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
